>>> rtl/assert_macros.svh
// assertion macros used by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/ibwt_pkg.sv
// shared types and constants for the inverse bwt decoder
package ibwt_pkg;

  // default sizes
  localparam int MAX_LEN_DEF  = 4096;
  localparam int ALPHABET_DEF = 256;

  // field widths
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int PIDX_W   = 12;
  localparam int STATUS_W = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FETCH = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // shared adder operations
  typedef enum logic {
    ALU_ADD,
    ALU_INC
  } alu_op_t;

endpackage

>>> rtl/ibwt_alu.sv
// shared adder used for counts, prefix sums, slot and length updates
module ibwt_alu
  import ibwt_pkg::*;
#(
  parameter int W = 13
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] y
);

  // add or increment
  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_INC: y = a + W'(1);
      default: y = a;
    endcase
  end

endmodule

>>> rtl/inverse_bwt_decoder.sv
// inverse burrows-wheeler decoder: sequencer, memories and shared adder
//
// Usage: a word is taken when start is high and busy is low. in_action
// selects load (append in_data_byte to the block), start (build the
// successor map from row in_primary_index) or fetch (return the next
// decoded byte). Action 3 is taken and ignored. Every other word gives
// one result on out_byte, out_is_last and out_status, marked by a single
// cycle out_valid pulse; the receiver cannot hold results off, and the
// pulse comes in the cycle busy drops; idle replies never raise busy.
// Steps from accept to result strobe:
//   load: count read, then count write-back
//   start: one count read and one slot write per byte value, then
//     store read, slot read and successor write per stored byte, each
//     step waiting on the read before
//   fetch: successor read, then symbol read
//   rejected start, empty fetch, overflowing load: answered from idle
// Reset (synchronous, rst_n low) empties the block at once: counts are
// marked invalid by per-value valid bits, so no clearing pass is needed
// and the block takes a word in the first cycle after reset.
module inverse_bwt_decoder
  import ibwt_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic [PIDX_W-1:0]   in_primary_index,
  output logic                out_valid,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_is_last,
  output logic [STATUS_W-1:0] out_status
);

`include "assert_macros.svh"

  localparam int AW  = $clog2(MAX_LEN);
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int SW  = $clog2(ALPHABET);
  localparam int CMW = (LW > PIDX_W) ? LW : PIDX_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_WR,
    S_PFX_RD,
    S_PFX_WR,
    S_WK_RD,
    S_WK_SLOT,
    S_WK_WR,
    S_FT_SYM,
    S_FT_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [AW-1:0]       cursor_r, cursor_nxt;
  logic [LW-1:0]       emit_r, emit_nxt;
  logic                ovf_r, ovf_nxt;
  logic                ready_r, ready_nxt;
  logic [ALPHABET-1:0] cnt_valid_r, cnt_valid_nxt;
  logic [SW-1:0]       v_r, v_nxt;
  logic [LW-1:0]       sum_r, sum_nxt;
  logic [LW-1:0]       i_r, i_nxt;
  logic [BYTE_W-1:0]   sym_r, sym_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // memories
  logic [BYTE_W-1:0] store_mem [MAX_LEN];
  logic [AW-1:0]     phi_mem   [MAX_LEN];
  logic [LW-1:0]     cnt_mem   [ALPHABET];
  logic [LW-1:0]     slot_mem  [ALPHABET];

  logic [BYTE_W-1:0] store_q;
  logic [AW-1:0]     phi_q;
  logic [LW-1:0]     cnt_q;
  logic [LW-1:0]     slot_q;

  logic              store_we;
  logic [AW-1:0]     store_wa, store_ra;
  logic [BYTE_W-1:0] store_wd;
  logic              phi_we;
  logic [AW-1:0]     phi_wa, phi_wd;
  logic              cnt_we;
  logic [SW-1:0]     cnt_wa, cnt_ra;
  logic [LW-1:0]     cnt_wd;
  logic              slot_we;
  logic [SW-1:0]     slot_wa, slot_ra;
  logic [LW-1:0]     slot_wd;

  // shared adder port
  alu_op_t       alu_op;
  logic [LW-1:0] alu_a, alu_b, alu_y;

  logic              accept;
  logic [LW-1:0]     eff_len;
  logic [BYTE_W-1:0] clamped;
  logic [SW-1:0]     cnt_sel;
  logic [LW-1:0]     cnt_val;
  logic [LW-1:0]     i_inc;
  logic [STATUS_W-1:0] ok_status;

  ibwt_alu #(
    .W(LW)
  ) u_alu (
    .op(alu_op),
    .a (alu_a),
    .b (alu_b),
    .y (alu_y)
  );

  assign busy        = (state_r != S_IDLE);
  assign accept      = start && !busy;
  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_last = out_last_r;
  assign out_status  = out_status_r;

  // helpers
  assign eff_len   = ready_r ? '0 : len_r;
  assign clamped   = ({1'b0, in_data_byte} >= (BYTE_W + 1)'(ALPHABET)) ?
                     BYTE_W'(ALPHABET - 1) : in_data_byte;
  assign cnt_sel   = (state_r == S_LD_WR) ? sym_r[SW-1:0] : v_r;
  assign cnt_val   = cnt_valid_r[cnt_sel] ? cnt_q : '0;
  assign i_inc     = i_r + LW'(1);
  assign ok_status = ovf_r ? ST_OVERFLOW : ST_OK;

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    cursor_nxt     = cursor_r;
    emit_nxt       = emit_r;
    ovf_nxt        = ovf_r;
    ready_nxt      = ready_r;
    cnt_valid_nxt  = cnt_valid_r;
    v_nxt          = v_r;
    sum_nxt        = sum_r;
    i_nxt          = i_r;
    sym_nxt        = sym_r;
    out_valid_nxt  = 1'b0;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    store_we = 1'b0;
    store_wa = eff_len[AW-1:0];
    store_wd = clamped;
    store_ra = i_r[AW-1:0];
    phi_we   = 1'b0;
    phi_wa   = slot_q[AW-1:0];
    phi_wd   = i_r[AW-1:0];
    cnt_we   = 1'b0;
    cnt_wa   = sym_r[SW-1:0];
    cnt_wd   = alu_y;
    cnt_ra   = clamped[SW-1:0];
    slot_we  = 1'b0;
    slot_wa  = v_r;
    slot_wd  = sum_r;
    slot_ra  = store_q[SW-1:0];

    alu_op = ALU_INC;
    alu_a  = eff_len;
    alu_b  = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_LOAD: begin
              // a load after a finished build opens a new block
              if (ready_r) begin
                cnt_valid_nxt = '0;
                emit_nxt      = '0;
                cursor_nxt    = '0;
                ovf_nxt       = 1'b0;
                ready_nxt     = 1'b0;
              end
              if (eff_len >= LW'(MAX_LEN)) begin
                len_nxt        = eff_len;
                ovf_nxt        = 1'b1;
                out_valid_nxt  = 1'b1;
                out_byte_nxt   = '0;
                out_last_nxt   = 1'b0;
                out_status_nxt = ST_OVERFLOW;
              end else begin
                store_we  = 1'b1;
                sym_nxt   = clamped;
                len_nxt   = alu_y;
                state_nxt = S_LD_WR;
              end
            end
            ACT_START: begin
              if (CMW'(in_primary_index) >= CMW'(len_r)) begin
                ready_nxt      = 1'b0;
                out_valid_nxt  = 1'b1;
                out_byte_nxt   = '0;
                out_last_nxt   = 1'b0;
                out_status_nxt = ST_RANGE;
              end else begin
                cursor_nxt = AW'(in_primary_index);
                emit_nxt   = '0;
                sum_nxt    = '0;
                v_nxt      = '0;
                i_nxt      = '0;
                state_nxt  = S_PFX_RD;
              end
            end
            ACT_FETCH: begin
              if (!ready_r || emit_r >= len_r) begin
                out_valid_nxt  = 1'b1;
                out_byte_nxt   = '0;
                out_last_nxt   = 1'b0;
                out_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_FT_SYM;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      // count write-back for a load
      S_LD_WR: begin
        alu_op         = ALU_INC;
        alu_a          = cnt_val;
        cnt_we         = 1'b1;
        cnt_wa         = sym_r[SW-1:0];
        cnt_wd         = alu_y;
        cnt_valid_nxt[sym_r[SW-1:0]] = 1'b1;
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = '0;
        out_last_nxt   = 1'b0;
        out_status_nxt = ok_status;
        state_nxt      = S_IDLE;
      end
      // exclusive prefix sums of the counts into the slot table
      S_PFX_RD: begin
        cnt_ra    = v_r;
        state_nxt = S_PFX_WR;
      end
      S_PFX_WR: begin
        slot_we = 1'b1;
        slot_wa = v_r;
        slot_wd = sum_r;
        alu_op  = ALU_ADD;
        alu_a   = sum_r;
        alu_b   = cnt_val;
        sum_nxt = alu_y;
        if (v_r == SW'(ALPHABET - 1)) begin
          state_nxt = S_WK_RD;
        end else begin
          v_nxt     = v_r + SW'(1);
          state_nxt = S_PFX_RD;
        end
      end
      // walk the store and fill the successor map
      S_WK_RD: begin
        store_ra  = i_r[AW-1:0];
        state_nxt = S_WK_SLOT;
      end
      S_WK_SLOT: begin
        sym_nxt   = store_q;
        slot_ra   = store_q[SW-1:0];
        state_nxt = S_WK_WR;
      end
      S_WK_WR: begin
        phi_we  = 1'b1;
        phi_wa  = slot_q[AW-1:0];
        phi_wd  = i_r[AW-1:0];
        alu_op  = ALU_INC;
        alu_a   = slot_q;
        slot_we = 1'b1;
        slot_wa = sym_r[SW-1:0];
        slot_wd = alu_y;
        if (i_inc == len_r) begin
          ready_nxt      = 1'b1;
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = '0;
          out_last_nxt   = 1'b0;
          out_status_nxt = ok_status;
          state_nxt      = S_IDLE;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_WK_RD;
        end
      end
      // follow one successor link and read its symbol
      S_FT_SYM: begin
        store_ra   = phi_q;
        cursor_nxt = phi_q;
        alu_op     = ALU_INC;
        alu_a      = emit_r;
        emit_nxt   = alu_y;
        state_nxt  = S_FT_OUT;
      end
      S_FT_OUT: begin
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = store_q;
        out_last_nxt   = (emit_r == len_r);
        out_status_nxt = ok_status;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      len_r        <= '0;
      cursor_r     <= '0;
      emit_r       <= '0;
      ovf_r        <= 1'b0;
      ready_r      <= 1'b0;
      cnt_valid_r  <= '0;
      out_valid_r  <= 1'b0;
      out_byte_r   <= '0;
      out_last_r   <= 1'b0;
      out_status_r <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      cursor_r     <= cursor_nxt;
      emit_r       <= emit_nxt;
      ovf_r        <= ovf_nxt;
      ready_r      <= ready_nxt;
      cnt_valid_r  <= cnt_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      out_byte_r   <= out_byte_nxt;
      out_last_r   <= out_last_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    sum_r <= sum_nxt;
    i_r   <= i_nxt;
    sym_r <= sym_nxt;
  end

  // symbol store
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_wa] <= store_wd;
    end
    store_q <= store_mem[store_ra];
  end

  // successor map, read at the cursor
  always_ff @(posedge clk) begin
    if (phi_we) begin
      phi_mem[phi_wa] <= phi_wd;
    end
    phi_q <= phi_mem[cursor_r];
  end

  // symbol counts
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_q <= cnt_mem[cnt_ra];
  end

  // next free slot per symbol
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_q <= slot_mem[slot_ra];
  end

  `ASSERT_IMPL(a_strobe_when_idle, out_valid_r, !busy, "result strobe while busy")
  `ASSERT_CLK(a_len_bound, len_r <= LW'(MAX_LEN), "block length beyond capacity")
  `ASSERT_IMPL(a_cursor_in_block, ready_r, LW'(cursor_r) < len_r, "cursor outside block")
  `ASSERT_IMPL(a_emit_bound, ready_r, emit_r <= len_r, "more bytes emitted than stored")

endmodule

>>> dv/tb.sv
// self-checking testbench for the inverse bwt decoder: directed table, random blocks, predictor
module tb;
  import ibwt_pkg::*;

  localparam int MAX_LEN  = MAX_LEN_DEF;
  localparam int ALPHABET = ALPHABET_DEF;
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int RAND_WORDS = 1820;
  localparam int MAX_REPORTS = 10;

  // one decoder reply
  typedef struct packed {
    logic [BYTE_W-1:0]   rbyte;
    logic                rlast;
    logic [STATUS_W-1:0] rstatus;
  } reply_t;

  // one line of the directed table; typed rows carry their own reply
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [BYTE_W-1:0]   dbyte;
    logic [BYTE_W-1:0]   bstep;
    logic [PIDX_W-1:0]   pidx;
    logic [12:0]         reps;
    logic                typed;
    logic [BYTE_W-1:0]   e_byte;
    logic                e_last;
    logic [STATUS_W-1:0] e_status;
  } dir_row_t;

  localparam int N_ROWS = 23;
  localparam int DUE_DEPTH = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] in_action;
  logic [BYTE_W-1:0]   in_data_byte;
  logic [PIDX_W-1:0]   in_primary_index;
  logic                out_valid;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_is_last;
  logic [STATUS_W-1:0] out_status;

  // sideband that travels with each word
  logic   tag_typed;
  reply_t tag_reply;

  // predictor state
  logic [BYTE_W-1:0] m_sym [0:MAX_LEN-1];
  logic [12:0]       m_cnt [0:ALPHABET-1];
  logic [11:0]       m_phi [0:MAX_LEN-1];
  logic [12:0]       m_len;
  logic [12:0]       m_emit;
  logic [11:0]       m_cur;
  bit                m_ovf;
  bit                m_rdy;

  // replies still due, oldest first
  reply_t   due_fifo [0:DUE_DEPTH-1];
  int       due_wr = 0;
  int       due_rd = 0;
  dir_row_t dir_rows [0:N_ROWS-1];

  int idle_pct;
  int words_sent;
  int err_count;
  int n_checked;
  int n_decodes;
  int n_range;
  int n_empty;
  int n_ovf;
  int n_last;

  inverse_bwt_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .in_primary_index (in_primary_index),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_is_last      (out_is_last),
    .out_status       (out_status)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // start a fresh block in the predictor
  task automatic ibwt_clear();
    for (int v = 0; v < ALPHABET; v++) m_cnt[v] = '0;
    m_len  = '0;
    m_cur  = '0;
    m_emit = '0;
    m_ovf  = 1'b0;
    m_rdy  = 1'b0;
  endtask

  // advance the predictor by one word and work out its reply
  task automatic ibwt_step(input logic [ACTION_W-1:0] a, input logic [BYTE_W-1:0] b,
                           input logic [PIDX_W-1:0] p, output bit has, output reply_t rep);
    int slot_next [0:ALPHABET-1];
    int sum;
    int slot;
    logic [11:0] j;
    has = 1'b1;
    rep = '0;
    case (a)
      ACT_LOAD: begin
        if (m_rdy) ibwt_clear();
        if (m_len >= MAX_LEN) begin
          m_ovf = 1'b1;
        end else begin
          // every 8 bit value lies inside the alphabet, so no clamp is needed
          m_sym[m_len] = b;
          m_cnt[b] = m_cnt[b] + 1'b1;
          m_len = m_len + 1'b1;
        end
        rep.rstatus = m_ovf ? ST_OVERFLOW : ST_OK;
      end
      ACT_START: begin
        if (p >= m_len) begin
          m_rdy = 1'b0;
          rep.rstatus = ST_RANGE;
        end else begin
          // exclusive prefix sums, then one walk over the store
          sum = 0;
          for (int v = 0; v < ALPHABET; v++) begin
            slot_next[v] = sum;
            sum += m_cnt[v];
          end
          for (int i = 0; i < m_len; i++) begin
            slot = slot_next[m_sym[i]];
            if (slot < MAX_LEN) m_phi[slot] = 12'(i);
            slot_next[m_sym[i]] = slot + 1;
          end
          m_cur  = p;
          m_emit = '0;
          m_rdy  = 1'b1;
          rep.rstatus = m_ovf ? ST_OVERFLOW : ST_OK;
        end
      end
      ACT_FETCH: begin
        if (!m_rdy || m_emit >= m_len) begin
          rep.rstatus = ST_EMPTY;
        end else begin
          j = m_phi[m_cur];
          rep.rbyte = m_sym[j];
          m_cur  = j;
          m_emit = m_emit + 1'b1;
          rep.rlast = (m_emit == m_len);
          rep.rstatus = m_ovf ? ST_OVERFLOW : ST_OK;
        end
      end
      default: has = 1'b0;
    endcase
  endtask

  // check replies, then predict for the word taken at this edge
  always @(posedge clk) begin : scoreboard
    bit     has;
    reply_t pred;
    reply_t want;
    if (!rst_n) begin
      ibwt_clear();
    end else begin
      if (out_valid) begin
        if (due_wr == due_rd) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("error: reply with none due: byte %0h last %0b status %0d",
                     out_byte, out_is_last, out_status);
        end else begin
          want = due_fifo[due_rd % DUE_DEPTH];
          due_rd++;
          n_checked++;
          if (out_byte !== want.rbyte || out_is_last !== want.rlast ||
              out_status !== want.rstatus) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("error: reply %0d expected byte %0h last %0b status %0d, got %0h %0b %0d",
                       n_checked, want.rbyte, want.rlast, want.rstatus,
                       out_byte, out_is_last, out_status);
          end
        end
      end
      if (start && !busy) begin
        ibwt_step(in_action, in_data_byte, in_primary_index, has, pred);
        if (has) begin
          if (pred.rstatus == ST_RANGE) n_range++;
          if (pred.rstatus == ST_EMPTY) n_empty++;
          if (pred.rstatus == ST_OVERFLOW) n_ovf++;
          if (pred.rlast) n_last++;
          if (in_action == ACT_START && pred.rstatus != ST_RANGE) n_decodes++;
          due_fifo[due_wr % DUE_DEPTH] = tag_typed ? tag_reply : pred;
          due_wr++;
        end
      end
    end
  end

  // present one word, with random idle cycles first, and wait until it is taken
  task automatic send_word(input logic [ACTION_W-1:0] a, input logic [BYTE_W-1:0] b,
                           input logic [PIDX_W-1:0] p, input logic typed, input reply_t er);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_action        <= a;
    in_data_byte     <= b;
    in_primary_index <= p;
    tag_typed        <= typed;
    tag_reply        <= er;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (a != ACT_NONE) words_sent++;
  endtask

  // hold off until every reply has come, plus room for an ignored word
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (due_wr != due_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    int       base;
    int       n;
    int       fcount;
    int       mode;
    int       r;
    logic [BYTE_W-1:0] b;
    logic [PIDX_W-1:0] p;
    reply_t   no_reply;
    dir_row_t row;

    no_reply = '0;
    start            <= 1'b0;
    in_action        <= ACT_LOAD;
    in_data_byte     <= '0;
    in_primary_index <= '0;
    tag_typed        <= 1'b0;
    tag_reply        <= '0;
    rst_n            <= 1'b0;
    idle_pct   = 28;
    words_sent = 0;
    err_count  = 0;
    n_checked  = 0;
    n_decodes  = 0;
    n_range    = 0;
    n_empty    = 0;
    n_ovf      = 0;
    n_last     = 0;

    dir_rows = '{
      // empty decoder: fetch and start both refused, unknown action ignored
      '{ACT_FETCH, 8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_EMPTY},
      '{ACT_START, 8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_RANGE},
      '{ACT_NONE,  8'hFF, 8'h00, 12'hFFF,  13'd1,    1'b0, 8'h00, 1'b0, ST_OK},
      // small block with byte extremes, index at and past the length
      '{ACT_LOAD,  8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      '{ACT_LOAD,  8'hFF, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      '{ACT_LOAD,  8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      '{ACT_START, 8'h00, 8'h00, 12'd3,    13'd1,    1'b1, 8'h00, 1'b0, ST_RANGE},
      '{ACT_START, 8'h00, 8'h00, 12'hFFF,  13'd1,    1'b1, 8'h00, 1'b0, ST_RANGE},
      // loads after a refused start keep appending
      '{ACT_LOAD,  8'h80, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      '{ACT_START, 8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      '{ACT_FETCH, 8'h00, 8'h00, 12'd0,    13'd4,    1'b0, 8'h00, 1'b0, ST_OK},
      '{ACT_FETCH, 8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_EMPTY},
      // repeated start restarts the decode
      '{ACT_START, 8'h00, 8'h00, 12'd2,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      '{ACT_FETCH, 8'h00, 8'h00, 12'd0,    13'd2,    1'b0, 8'h00, 1'b0, ST_OK},
      '{ACT_START, 8'h00, 8'h00, 12'd1,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      '{ACT_FETCH, 8'h00, 8'h00, 12'd0,    13'd1,    1'b0, 8'h00, 1'b0, ST_OK},
      // a refused start ends the decode
      '{ACT_START, 8'h00, 8'h00, 12'hFFF,  13'd1,    1'b1, 8'h00, 1'b0, ST_RANGE},
      '{ACT_FETCH, 8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_EMPTY},
      '{ACT_START, 8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      // load during a decode opens a new block
      '{ACT_LOAD,  8'h5A, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      '{ACT_FETCH, 8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_EMPTY},
      '{ACT_START, 8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h00, 1'b0, ST_OK},
      '{ACT_FETCH, 8'h00, 8'h00, 12'd0,    13'd1,    1'b1, 8'h5A, 1'b1, ST_OK}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_ROWS; i++) begin
      row = dir_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        b = row.dbyte + 8'(k) * row.bstep;
        send_word(row.act, b, row.pidx, row.typed, {row.e_byte, row.e_last, row.e_status});
      end
    end
    drain();

    // random blocks in three idle phases
    base = words_sent;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 28 : (phase == 1) ? 58 : 0;
      while (words_sent - base < (phase + 1) * RAND_WORDS / 3) begin
        r = $urandom_range(99);
        if (r < 8) begin
          // noise word
          send_word(2'($urandom_range(3)), 8'($urandom), 12'($urandom), 1'b0, no_reply);
        end else begin
          n = (r < 12) ? $urandom_range(100, 300) : $urandom_range(1, 24);
          mode = $urandom_range(2);
          for (int k = 0; k < n; k++) begin
            if (mode == 0) b = 8'($urandom);
            else if (mode == 1) b = 8'($urandom_range(3));
            else b = $urandom_range(1) ? 8'hFF : 8'h00;
            send_word(ACT_LOAD, b, 12'($urandom), 1'b0, no_reply);
          end
          if (r < 20) p = 12'($urandom_range(n, MAX_LEN - 1));
          else p = 12'($urandom_range(n - 1));
          send_word(ACT_START, 8'($urandom), p, 1'b0, no_reply);
          fcount = ($urandom_range(99) < 80) ? n + $urandom_range(2) : $urandom_range(n);
          for (int k = 0; k < fcount; k++)
            send_word(ACT_FETCH, 8'($urandom), 12'($urandom), 1'b0, no_reply);
          // sometimes restart the same block mid-way
          if (r % 3 == 0) begin
            send_word(ACT_START, 8'($urandom), 12'($urandom_range(n - 1)), 1'b0, no_reply);
            fcount = $urandom_range(n + 1);
            for (int k = 0; k < fcount; k++)
              send_word(ACT_FETCH, 8'($urandom), 12'($urandom), 1'b0, no_reply);
          end
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d words, %0d replies checked, %0d decodes, %0d last bytes",
             words_sent, n_checked, n_decodes, n_last);
    $display("refused starts %0d, empty fetches %0d, overflow replies %0d, mismatches %0d",
             n_range, n_empty, n_ovf, err_count);
    if (err_count == 0 && due_wr == due_rd) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
